>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the terminal RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define TTS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked check that also holds during reset.
`define TTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/tts_pkg.sv
package tts_pkg;

   // Default screen geometry
   localparam int COLS_DEF = 80;
   localparam int ROWS_DEF = 25;

   // Field widths
   localparam int CELL_W = 16;
   localparam int POS_W  = 11;

   // Character codes
   localparam logic [7:0] BS_CHAR    = 8'h08;
   localparam logic [7:0] NL_CHAR    = 8'h0A;
   localparam logic [7:0] BLANK_CHAR = 8'h20;

   // Attribute after reset: white on black
   localparam logic [7:0] RESET_COLOR = 8'h0F;

   // Operation codes
   localparam logic [1:0] MODE_PUT   = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // Finished result handed from the sequencer to the output register
   typedef struct packed {
      logic                fire;
      logic [CELL_W-1:0]   cell_data;
      logic [POS_W-1:0]    pos;
      logic                wr;
   } result_type;

endpackage

>>> rtl/core/tts_screen_ram.sv
// Single-port-write, single-port-read screen store with registered read data.
module tts_screen_ram #(
   parameter int  DEPTH  = tts_pkg::COLS_DEF * tts_pkg::ROWS_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [tts_pkg::CELL_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [tts_pkg::CELL_W-1:0] rd_data
);

   logic [tts_pkg::CELL_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/core/tts_ctrl.sv
`include "assert_macros.svh"

// Command sequencer: cursor registers, sweep address counter and store access.
module tts_ctrl #(
   parameter int  COLS   = tts_pkg::COLS_DEF,
   parameter int  ROWS   = tts_pkg::ROWS_DEF,
   localparam int CELLS  = COLS * ROWS,
   localparam int ADDR_W = $clog2(CELLS),
   localparam int COL_W  = $clog2(COLS),
   localparam int ROW_W  = $clog2(ROWS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_fire,
   input  logic [1:0]          mode,
   input  logic [7:0]          char_code,
   input  logic [4:0]          read_row,
   input  logic [6:0]          read_col,
   input  logic [7:0]          text_color,
   input  logic                slot_free,
   output logic                req_ready,
   output tts_pkg::result_type result
);

   localparam int CELL_W = tts_pkg::CELL_W;
   localparam int POS_W  = tts_pkg::POS_W;

   typedef enum logic [7:0] {
      ST_INIT       = 8'b0000_0001,
      ST_IDLE       = 8'b0000_0010,
      ST_EXEC       = 8'b0000_0100,
      ST_READ       = 8'b0000_1000,
      ST_SCROLL     = 8'b0001_0000,
      ST_SHIFT_LAST = 8'b0010_0000,
      ST_BLANK      = 8'b0100_0000,
      ST_DONE       = 8'b1000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [1:0]          mode_ff, mode_in;
   logic [7:0]          char_ff, char_in;
   logic [4:0]          rr_ff, rr_in;
   logic [6:0]          rc_ff, rc_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   logic [ADDR_W-1:0]   sweep_ff, sweep_in;
   logic                pend_ff, pend_in;
   logic [ADDR_W-1:0]   pend_addr_ff, pend_addr_in;
   logic [CELL_W-1:0]   cell_ff, cell_in;
   logic                in_range_ff, in_range_in;
   logic                rep_valid_ff, rep_valid_in;
   logic [ADDR_W-1:0]   last_pos_ff, last_pos_in;

   logic                mem_wr_en;
   logic [ADDR_W-1:0]   mem_wr_addr;
   logic [CELL_W-1:0]   mem_wr_data;
   logic                mem_rd_en;
   logic [ADDR_W-1:0]   mem_rd_addr;
   logic [CELL_W-1:0]   mem_rd_data;

   logic [CELL_W-1:0]   blank_cell;
   logic                col_last, row_last, col_zero, row_zero;
   logic                reports, pos_changed;

   assign blank_cell  = {text_color, tts_pkg::BLANK_CHAR};
   assign col_last    = (col_ff == COL_W'(COLS - 1));
   assign row_last    = (row_ff == ROW_W'(ROWS - 1));
   assign col_zero    = (col_ff == '0);
   assign row_zero    = (row_ff == '0);
   assign reports     = (mode_ff == tts_pkg::MODE_PUT) || (mode_ff == tts_pkg::MODE_CLEAR);
   assign pos_changed = !rep_valid_ff || (last_pos_ff != pos_ff);
   assign req_ready   = (state_ff == ST_IDLE);

   tts_screen_ram #(.DEPTH(CELLS)) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      char_in      = char_ff;
      rr_in        = rr_ff;
      rc_in        = rc_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pos_in       = pos_ff;
      sweep_in     = sweep_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      cell_in      = cell_ff;
      in_range_in  = in_range_ff;
      rep_valid_in = rep_valid_ff;
      last_pos_in  = last_pos_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = sweep_ff;
      mem_wr_data  = blank_cell;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = sweep_ff;
      result.fire      = 1'b0;
      result.cell_data = cell_ff;
      result.pos       = POS_W'(pos_ff);
      result.wr        = reports && pos_changed;

      case (state_ff)
         // blank the store after reset, fixed attribute
         ST_INIT: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = {tts_pkg::RESET_COLOR, tts_pkg::BLANK_CHAR};
            if (sweep_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               mode_in  = mode;
               char_in  = char_code;
               rr_in    = read_row;
               rc_in    = read_col;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            cell_in  = '0;
            state_in = ST_DONE;
            case (mode_ff)
               tts_pkg::MODE_PUT: begin
                  if (char_ff == tts_pkg::BS_CHAR) begin
                     // step back, across line starts, and blank the landing cell
                     mem_wr_en = 1'b1;
                     mem_wr_addr = pos_ff;
                     if (!col_zero) begin
                        col_in      = col_ff - COL_W'(1);
                        pos_in      = pos_ff - ADDR_W'(1);
                        mem_wr_addr = pos_ff - ADDR_W'(1);
                     end else if (!row_zero) begin
                        row_in      = row_ff - ROW_W'(1);
                        col_in      = COL_W'(COLS - 1);
                        pos_in      = pos_ff - ADDR_W'(1);
                        mem_wr_addr = pos_ff - ADDR_W'(1);
                     end
                  end else if (char_ff == tts_pkg::NL_CHAR) begin
                     col_in = '0;
                     if (row_last) begin
                        pos_in   = pos_ff - ADDR_W'(col_ff);
                        sweep_in = ADDR_W'(COLS);
                        pend_in  = 1'b0;
                        state_in = ST_SCROLL;
                     end else begin
                        row_in = row_ff + ROW_W'(1);
                        pos_in = pos_ff - ADDR_W'(col_ff) + ADDR_W'(COLS);
                     end
                  end else begin
                     // write and advance, wrapping at line end and scrolling past the last line
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = pos_ff;
                     mem_wr_data = {text_color, char_ff};
                     if (!col_last) begin
                        col_in = col_ff + COL_W'(1);
                        pos_in = pos_ff + ADDR_W'(1);
                     end else if (!row_last) begin
                        col_in = '0;
                        row_in = row_ff + ROW_W'(1);
                        pos_in = pos_ff + ADDR_W'(1);
                     end else begin
                        col_in   = '0;
                        pos_in   = pos_ff + ADDR_W'(1) - ADDR_W'(COLS);
                        sweep_in = ADDR_W'(COLS);
                        pend_in  = 1'b0;
                        state_in = ST_SCROLL;
                     end
                  end
               end
               tts_pkg::MODE_CLEAR: begin
                  col_in   = '0;
                  row_in   = '0;
                  pos_in   = '0;
                  sweep_in = '0;
                  state_in = ST_BLANK;
               end
               tts_pkg::MODE_READ: begin
                  in_range_in = (int'(rr_ff) < ROWS) && (int'(rc_ff) < COLS);
                  mem_rd_en   = (int'(rr_ff) < ROWS) && (int'(rc_ff) < COLS);
                  mem_rd_addr = ADDR_W'(int'(rr_ff) * COLS + int'(rc_ff));
                  state_in    = ST_READ;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         ST_READ: begin
            cell_in  = in_range_ff ? mem_rd_data : '0;
            state_in = ST_DONE;
         end

         // move every line up: read one cell, write the previously read cell one line higher
         ST_SCROLL: begin
            mem_rd_en    = 1'b1;
            mem_rd_addr  = sweep_ff;
            mem_wr_en    = pend_ff;
            mem_wr_addr  = pend_addr_ff;
            mem_wr_data  = mem_rd_data;
            pend_in      = 1'b1;
            pend_addr_in = sweep_ff - ADDR_W'(COLS);
            if (sweep_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_SHIFT_LAST;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end

         ST_SHIFT_LAST: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = pend_addr_ff;
            mem_wr_data = mem_rd_data;
            pend_in     = 1'b0;
            sweep_in    = ADDR_W'(CELLS - COLS);
            state_in    = ST_BLANK;
         end

         // blank from the sweep address to the end of the store
         ST_BLANK: begin
            mem_wr_en = 1'b1;
            if (sweep_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_DONE;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end

         ST_DONE: begin
            if (slot_free) begin
               result.fire = 1'b1;
               state_in    = ST_IDLE;
               if (reports && pos_changed) begin
                  rep_valid_in = 1'b1;
                  last_pos_in  = pos_ff;
               end
            end
         end

         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         pos_ff       <= '0;
         pend_ff      <= 1'b0;
         rep_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pos_ff       <= pos_in;
         pend_ff      <= pend_in;
         rep_valid_ff <= rep_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      char_ff      <= char_in;
      rr_ff        <= rr_in;
      rc_ff        <= rc_in;
      pend_addr_ff <= pend_addr_in;
      cell_ff      <= cell_in;
      in_range_ff  <= in_range_in;
      last_pos_ff  <= last_pos_in;
   end

   `TTS_ASSERT(a_idle_no_write, clock, reset,
      (state_ff == ST_IDLE) |-> !mem_wr_en, "store written while idle")
   `TTS_ASSERT(a_fire_slot, clock, reset,
      result.fire |-> slot_free, "result issued into a full output register")
   `TTS_ASSERT(a_cursor_bounds, clock, reset,
      (int'(row_ff) < ROWS) && (int'(col_ff) < COLS), "cursor outside the screen")
   `TTS_ASSERT(a_cursor_linear, clock, reset,
      (state_ff == ST_IDLE) |-> (int'(pos_ff) == int'(row_ff) * COLS + int'(col_ff)),
      "linear cursor out of step with row and column")

endmodule

>>> rtl/core/text_terminal_cursor_scroll.sv
// Character-cell text terminal with a ROWS x COLS store of 16-bit cells (attribute in the
// high byte, character in the low byte). Request tuser carries the operation (put, clear,
// read); every request gives exactly one response with the cell read, the linear cursor
// position and a flag that is set when a put or clear leaves that position different from
// the last one reported. All work is done by one sequencer driving one store write port and
// one read port, so the block takes one request at a time. After the transfer a read adds a
// store read step, a clear blanks the whole store, and a put or newline that scrolls copies
// one cell per cycle followed by blanking the bottom line. The next request can be taken in
// the cycle after the result is issued; a result waits in the sequencer while the response
// register is still held by the receiver. After reset the store is blanked one cell per
// cycle before the first request is taken; text color writes are accepted throughout. A
// finished result waits in the response register while the next request is accepted.
`include "assert_macros.svh"

module text_terminal_cursor_scroll #(
   parameter int COLS = tts_pkg::COLS_DEF,
   parameter int ROWS = tts_pkg::ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13], zero
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // cell_value[15:0], cursor_pos[26:16], cursor_write[27]
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data  // text_color
);

   tts_pkg::result_type result;

   logic [7:0]                 text_color_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [tts_pkg::CELL_W-1:0] rsp_cell_ff;
   logic [tts_pkg::POS_W-1:0]  rsp_pos_ff;
   logic                       rsp_wr_ff;
   logic                       slot_free;
   logic                       req_fire;

   assign req_fire  = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   tts_ctrl #(.COLS(COLS), .ROWS(ROWS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .mode       (req_tuser),
      .char_code  (req_tdata[7:0]),
      .read_row   (req_tdata[12:8]),
      .read_col   (req_tdata[19:13]),
      .text_color (text_color_ff),
      .slot_free  (slot_free),
      .req_ready  (req_tready),
      .result     (result)
   );

   // Text color register
   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= tts_pkg::RESET_COLOR;
      end else if (csr_wr_en) begin
         text_color_ff <= csr_wr_data;
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result.fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.fire) begin
         rsp_cell_ff <= result.cell_data;
         rsp_pos_ff  <= result.pos;
         rsp_wr_ff   <= result.wr;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_wr_ff, rsp_pos_ff, rsp_cell_ff};

   `TTS_ASSERT(a_busy_after_accept, clock, reset,
      req_fire |=> !req_tready, "request taken while previous one in progress")
   `TTS_ASSERT(a_result_lands, clock, reset,
      result.fire |=> rsp_tvalid, "finished result not presented")

endmodule

>>> verif/text_terminal_cursor_scroll_tb.sv
`timescale 1ns / 100ps

module text_terminal_cursor_scroll_tb;

   localparam int COLS        = tts_pkg::COLS_DEF;
   localparam int ROWS        = tts_pkg::ROWS_DEF;
   localparam int CELL_CNT    = COLS * ROWS;
   localparam int PHASE_ITEMS = 325;
   localparam int MAX_REPORTS = 10;
   localparam int HOLD_CYCLES = 300;

   // mode 3 has no package name; the block treats it as a no-op
   localparam logic [1:0] MODE_NOP = 2'd3;

   typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_MOSTLY} rdy_style_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } term_cmd_type;

   typedef struct packed {
      logic        cursor_write;
      logic [10:0] cursor_pos;
      logic [15:0] cell_value;
   } term_rsp_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;   // char_code[7:0], read_row[12:8], read_col[19:13], zero
   logic [1:0]  req_tuser   = '0;   // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;          // cell_value[15:0], cursor_pos[26:16], cursor_write[27]
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   text_terminal_cursor_scroll dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // shadow of the terminal state
   logic [15:0] screen_copy [CELL_CNT];
   int unsigned cur_row;
   int unsigned cur_col;
   logic [15:0] last_pos;
   logic [7:0]  attr_color;

   term_cmd_type cmd_q[$];
   term_rsp_type expect_q[$];
   int           queued_cnt   = 0;
   int           accepted_cnt = 0;
   int           rsp_cnt      = 0;
   int           err_cnt      = 0;
   int           hold_left    = 0;

   // apply one command to the shadow state, return the response it should give
   function automatic term_rsp_type terminal_step(term_cmd_type c);
      term_rsp_type res;
      int unsigned  pos;
      res = '0;
      case (c.mode)
         tts_pkg::MODE_PUT: begin
            if (c.char_code == tts_pkg::BS_CHAR) begin
               if (cur_col > 0) begin
                  cur_col--;
               end else if (cur_row > 0) begin
                  cur_row--;
                  cur_col = COLS - 1;
               end
               screen_copy[cur_row * COLS + cur_col] = {attr_color, tts_pkg::BLANK_CHAR};
            end else begin
               if (c.char_code == tts_pkg::NL_CHAR) begin
                  cur_col = 0;
                  cur_row++;
               end else begin
                  screen_copy[cur_row * COLS + cur_col] = {attr_color, c.char_code};
                  cur_col++;
                  if (cur_col >= COLS) begin
                     cur_col = 0;
                     cur_row++;
                  end
               end
               // scroll: shift lines up, blank the bottom one
               if (cur_row >= ROWS) begin
                  for (int i = COLS; i < CELL_CNT; i++)
                     screen_copy[i - COLS] = screen_copy[i];
                  for (int i = CELL_CNT - COLS; i < CELL_CNT; i++)
                     screen_copy[i] = {attr_color, tts_pkg::BLANK_CHAR};
                  cur_row = ROWS - 1;
               end
            end
         end
         tts_pkg::MODE_CLEAR: begin
            for (int i = 0; i < CELL_CNT; i++)
               screen_copy[i] = {attr_color, tts_pkg::BLANK_CHAR};
            cur_row = 0;
            cur_col = 0;
         end
         tts_pkg::MODE_READ: begin
            if (c.read_row < ROWS && c.read_col < COLS)
               res.cell_value = screen_copy[c.read_row * COLS + c.read_col];
         end
         default: ;
      endcase
      pos = cur_row * COLS + cur_col;
      // cursor register written only on a change of the full position
      if (c.mode == tts_pkg::MODE_PUT || c.mode == tts_pkg::MODE_CLEAR) begin
         if (pos[15:0] != last_pos) begin
            last_pos         = pos[15:0];
            res.cursor_write = 1'b1;
         end
      end
      res.cursor_pos = pos[10:0];
      return res;
   endfunction

   // request driver: bursts of transfers with random gaps
   always @(posedge clock) begin : drive_req
      term_cmd_type cur_cmd;
      int           burst_left;
      int           gap_left;
      logic         offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            expect_q.push_back(terminal_step(cur_cmd));
            accepted_cnt++;
            offer = 1'b0;
         end
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (cmd_q.size() > 0) begin
               cur_cmd = cmd_q.pop_front();
               req_tdata <= {4'b0, cur_cmd.read_col, cur_cmd.read_row, cur_cmd.char_code};
               req_tuser <= cur_cmd.mode;
               offer = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_tvalid <= offer;
      end
   end

   // response ready: switches among random stall styles
   always @(posedge clock) begin : drive_ready
      rdy_style_type style;
      int            style_left;
      logic          rdy;
      if (style_left <= 0) begin
         style      = rdy_style_type'($urandom_range(0, 3));
         style_left = $urandom_range(32, 400);
      end else begin
         style_left--;
      end
      case (style)
         RDY_ALWAYS: rdy = 1'b1;
         RDY_COIN:   rdy = 1'($urandom_range(0, 1));
         RDY_SPARSE: rdy = (style_left % 4 == 0);
         default:    rdy = ($urandom_range(0, 9) != 0);
      endcase
      rsp_tready <= rdy && (hold_left == 0);
   end

   // long receiver hold-off so the block backs up onto its input
   always @(posedge clock) begin : long_hold
      if (hold_left > 0)
         hold_left <= hold_left - 1;
      else if (rsp_tvalid && rsp_tready && rsp_cnt % 700 == 350)
         hold_left <= HOLD_CYCLES;
   end

   // response checker
   always @(posedge clock) begin : check_rsp
      term_rsp_type want;
      term_rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.cell_value   = rsp_tdata[15:0];
         got.cursor_pos   = rsp_tdata[26:16];
         got.cursor_write = rsp_tdata[27];
         rsp_cnt <= rsp_cnt + 1;
         if (expect_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
               $display("%0t: response with none expected: cell %h pos %0d wr %b",
                        $realtime, got.cell_value, got.cursor_pos, got.cursor_write);
         end else begin
            want = expect_q.pop_front();
            if (got.cell_value !== want.cell_value || got.cursor_pos !== want.cursor_pos ||
                got.cursor_write !== want.cursor_write) begin
               err_cnt++;
               if (err_cnt <= MAX_REPORTS)
                  $display("%0t: response %0d: cell %h/%h pos %0d/%0d wr %b/%b (exp/got)",
                           $realtime, rsp_cnt, want.cell_value, got.cell_value,
                           want.cursor_pos, got.cursor_pos, want.cursor_write,
                           got.cursor_write);
            end
         end
      end
   end

   task automatic queue_cmd(logic [1:0] mode, logic [7:0] chr, logic [4:0] row,
                            logic [6:0] col);
      term_cmd_type c;
      c.mode      = mode;
      c.char_code = chr;
      c.read_row  = row;
      c.read_col  = col;
      cmd_q.push_back(c);
      queued_cnt++;
   endtask

   // all queued commands accepted and answered
   task automatic wait_idle();
      while (accepted_cnt != queued_cnt || expect_q.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_color(logic [7:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      attr_color  = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : stimulus
      term_cmd_type c;
      int           pick;
      logic [7:0]   colors [6];

      for (int i = 0; i < CELL_CNT; i++)
         screen_copy[i] = 16'h0F20;
      cur_row    = 0;
      cur_col    = 0;
      last_pos   = 16'hFFFF;
      attr_color = tts_pkg::RESET_COLOR;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: reset contents, range edges, backspace cases, no-op, clear
      queue_cmd(tts_pkg::MODE_READ, 8'h00, 5'd0, 7'd0);
      queue_cmd(tts_pkg::MODE_READ, 8'hFF, 5'd24, 7'd79);
      queue_cmd(tts_pkg::MODE_READ, 8'h00, 5'd25, 7'd0);
      queue_cmd(tts_pkg::MODE_READ, 8'h00, 5'd31, 7'd127);
      queue_cmd(tts_pkg::MODE_READ, 8'h00, 5'd0, 7'd80);
      queue_cmd(tts_pkg::MODE_PUT, tts_pkg::BS_CHAR, 5'd0, 7'd0);   // backspace at home
      queue_cmd(tts_pkg::MODE_PUT, 8'h41, 5'd31, 7'd127);
      queue_cmd(tts_pkg::MODE_PUT, 8'hFF, 5'd0, 7'd0);
      queue_cmd(tts_pkg::MODE_PUT, 8'h00, 5'd0, 7'd0);
      queue_cmd(tts_pkg::MODE_PUT, tts_pkg::NL_CHAR, 5'd0, 7'd0);
      queue_cmd(tts_pkg::MODE_PUT, tts_pkg::BS_CHAR, 5'd0, 7'd0);   // back across line start
      queue_cmd(tts_pkg::MODE_PUT, tts_pkg::BS_CHAR, 5'd0, 7'd0);
      queue_cmd(tts_pkg::MODE_READ, 8'h00, 5'd0, 7'd0);
      queue_cmd(tts_pkg::MODE_READ, 8'h00, 5'd0, 7'd1);
      queue_cmd(tts_pkg::MODE_READ, 8'h00, 5'd0, 7'd79);
      queue_cmd(MODE_NOP, 8'hFF, 5'd31, 7'd127);
      queue_cmd(tts_pkg::MODE_PUT, 8'h7E, 5'd0, 7'd0);
      queue_cmd(tts_pkg::MODE_CLEAR, 8'hFF, 5'd31, 7'd127);
      queue_cmd(tts_pkg::MODE_CLEAR, 8'h00, 5'd0, 7'd0);   // same position, no cursor write
      queue_cmd(tts_pkg::MODE_READ, 8'h00, 5'd0, 7'd1);
      queue_cmd(tts_pkg::MODE_PUT, tts_pkg::NL_CHAR, 5'd0, 7'd0);
      queue_cmd(tts_pkg::MODE_PUT, 8'h5A, 5'd0, 7'd0);
      queue_cmd(tts_pkg::MODE_READ, 8'h00, 5'd1, 7'd0);
      queue_cmd(MODE_NOP, 8'h00, 5'd0, 7'd0);
      wait_idle();

      colors = '{8'h00, 8'hFF, 8'h00, 8'h80, 8'h00, 8'h07};
      colors[2] = 8'($urandom_range(0, 255));
      colors[4] = 8'($urandom_range(0, 255));

      // random phases, one text color each; mostly text and newlines so the
      // cursor reaches the bottom and scrolls, clears kept rare
      for (int ph = 0; ph < 6; ph++) begin
         write_color(colors[ph]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            c    = 22'($urandom);
            pick = $urandom_range(0, 999);
            if (pick < 630) begin
               c.mode = tts_pkg::MODE_PUT;
            end else if (pick < 730) begin
               c.mode      = tts_pkg::MODE_PUT;
               c.char_code = tts_pkg::NL_CHAR;
            end else if (pick < 790) begin
               c.mode      = tts_pkg::MODE_PUT;
               c.char_code = tts_pkg::BS_CHAR;
            end else if (pick < 940) begin
               c.mode = tts_pkg::MODE_READ;
               if ($urandom_range(0, 9) < 7) begin
                  c.read_row = 5'($urandom_range(0, ROWS - 1));
                  c.read_col = 7'($urandom_range(0, COLS - 1));
               end
            end else if (pick < 980) begin
               c.mode = MODE_NOP;
            end else begin
               c.mode = ($urandom_range(0, 9) == 0) ? tts_pkg::MODE_CLEAR : tts_pkg::MODE_PUT;
            end
            cmd_q.push_back(c);
            queued_cnt++;
         end
         wait_idle();
      end

      repeat (30) @(posedge clock);
      if (err_cnt == 0 && expect_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // run limit
   initial begin
      #500_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
